// ===== rtl/sbus_frame_decoder_defines.svh =====
// Assertion macros for the frame decoder. Each use sits on a line of its own.
`ifndef SBUS_FRAME_DECODER_DEFINES_SVH
`define SBUS_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define SBD_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("assertion failed after reset");
`else
`define SBD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define SBD_ASSERT_RESET(label, clk, rst_n, cons)
`endif

`endif

// ===== rtl/sbd_pkg.sv =====
`default_nettype none

package sbd_pkg;

    localparam int FRAME_BYTES     = 25;
    localparam int POS_W           = $clog2(FRAME_BYTES);
    localparam int FLAGS_POS       = 23;
    localparam int END_POS         = 24;
    localparam int LOST_BIT        = 2;
    localparam int DATA_BYTES      = 22;
    localparam int FRAME_DATA_BITS = DATA_BYTES * 8;
    localparam int CHAN_BITS       = 11;
    localparam int CHAN_IDX_W      = 4;
    localparam int VALUE_W         = 12;
    localparam int CHAN_OFFSET     = 1024;
    localparam int AGE_W           = 16;
    localparam int FS_W            = 11;

    // Reciprocal constants, exact over the whole 11-bit range of the full scale.
    localparam int RECIP10       = 52429;
    localparam int RECIP10_SHIFT = 19;
    localparam int RECIP25       = 5243;
    localparam int RECIP25_SHIFT = 17;
    localparam int PROD_W        = FS_W + 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRESHNESS_MS = 2'd2;

    localparam logic KIND_BYTE      = 1'b0;
    localparam logic KIND_TICK      = 1'b1;
    localparam logic REPORT_CHANNEL = 1'b0;
    localparam logic REPORT_STATUS  = 1'b1;

    localparam logic [7:0]       END_MARKER_RESET = 8'd0;
    localparam logic [FS_W-1:0]  FULL_SCALE_RESET = 11'd800;
    localparam logic [AGE_W-1:0] FRESHNESS_RESET  = 16'd100;
    localparam logic [AGE_W-1:0] AGE_MAX          = 16'hFFFF;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic                      report_kind;
        logic [CHAN_IDX_W-1:0]     channel_index;
        logic signed [VALUE_W-1:0] channel_value;
        logic [1:0]                switch_position;
        logic                      stick_centered;
        logic                      stick_high;
        logic                      stick_low;
        logic [7:0]                flags_byte;
        logic                      stale;
        logic                      last;
    } t_out_word;

    typedef struct packed {
        logic                       is_status;
        logic [FRAME_DATA_BITS-1:0] bits;
        logic [7:0]                 flags;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== rtl/sbd_in_if.sv =====
`default_nettype none

interface sbd_in_if;
    logic              valid;
    logic              ready;
    sbd_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbd_out_if.sv =====
`default_nettype none

interface sbd_out_if;
    logic               valid;
    logic               ready;
    sbd_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sbd_front.sv =====
`default_nettype none

module sbd_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    sbd_in_if.sink                           i_in,
    input  wire logic [7:0]                  i_end_marker,
    input  wire logic [sbd_pkg::AGE_W-1:0]   i_freshness_ms,
    input  sbd_pkg::t_queue_status           i_qstat,
    output logic                             o_push,
    output sbd_pkg::t_job                    o_job
);
    import sbd_pkg::*;

    logic                       r_in_frame, n_in_frame;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic                       r_stale, n_stale;
    logic [AGE_W-1:0]           r_age, n_age;
    logic [FRAME_DATA_BITS-1:0] r_bits, n_bits;
    logic [7:0]                 r_flags, n_flags;

    logic             w_accept;
    logic             w_active;
    logic [POS_W-1:0] w_pos;

    assign i_in.ready = !i_qstat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_active   = i_in.data.frame_start || r_in_frame;
    assign w_pos      = i_in.data.frame_start ? '0 : r_pos;

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_stale    = r_stale;
        n_age      = r_age;
        n_bits     = r_bits;
        n_flags    = r_flags;
        o_push     = 1'b0;
        o_job.is_status = 1'b0;
        o_job.bits      = r_bits;
        o_job.flags     = r_flags;
        if (w_accept) begin
            if (i_in.data.kind == KIND_TICK) begin
                n_age = (r_age == AGE_MAX) ? r_age : r_age + 1'b1;
                if (!r_stale && (n_age > i_freshness_ms)) begin
                    n_stale         = 1'b1;
                    o_push          = 1'b1;
                    o_job.is_status = 1'b1;
                end
            end else if (w_active) begin
                n_in_frame = 1'b1;
                if (w_pos == POS_W'(END_POS)) begin
                    // The end byte is checked as it arrives; it needs no storage.
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                    if ((i_in.data.byte_value == i_end_marker) && !r_flags[LOST_BIT]) begin
                        n_stale = 1'b0;
                        n_age   = '0;
                        o_push  = 1'b1;
                    end
                end else begin
                    n_pos = w_pos + 1'b1;
                    if (w_pos == POS_W'(FLAGS_POS)) begin
                        n_flags = i_in.data.byte_value;
                    end else if (w_pos != '0) begin
                        // Data bytes shift in from the top, so byte 1 ends at bit 0.
                        n_bits = {i_in.data.byte_value, r_bits[FRAME_DATA_BITS-1:8]};
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_stale    <= 1'b0;
            r_age      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_stale    <= n_stale;
            r_age      <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits  <= n_bits;
        r_flags <= n_flags;
    end

endmodule

`default_nettype wire

// ===== rtl/sbd_queue.sv =====
`default_nettype none

module sbd_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  sbd_pkg::t_job           i_job,
    input  wire logic               i_pop,
    output sbd_pkg::t_job           o_job,
    output sbd_pkg::t_queue_status  o_status
);
    import sbd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    logic w_push, w_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_job  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sbd_back.sv =====
`default_nettype none

module sbd_back #(
    parameter int CHANNELS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [sbd_pkg::FS_W-1:0]   i_full_scale,
    input  wire logic                       i_job_valid,
    input  sbd_pkg::t_job                   i_job,
    output logic                            o_pop,
    sbd_out_if.source                       o_out
);
    import sbd_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [FS_W-1:0] r_q10, r_q25;
    logic [PROD_W-1:0] w_prod10, w_prod25;

    logic                       r_busy;
    logic                       r_is_status;
    logic [FRAME_DATA_BITS-1:0] r_bits;
    logic [7:0]                 r_flags;
    logic [CH_W-1:0]            r_chan;
    logic                       r_out_valid;
    t_out_word                  r_out;

    logic                      w_out_free;
    logic                      w_emit;
    logic                      w_last;
    logic [CHAN_BITS-1:0]      w_raw;
    logic [VALUE_W-1:0]        w_v;
    logic signed [VALUE_W:0]   w_v13, w_half13, w_edge13;
    logic [VALUE_W-1:0]        w_mag;
    logic [FS_W-1:0]           w_edge;
    logic                      w_gt_neg_half, w_gt_half;
    t_out_word                 w_result;

    // The threshold quotients are registered, so they follow the full-scale register in the next cycle.
    assign w_prod10 = PROD_W'(i_full_scale) * PROD_W'(RECIP10);
    assign w_prod25 = PROD_W'(i_full_scale) * PROD_W'(RECIP25);

    always_ff @(posedge i_clk) begin
        r_q10 <= FS_W'(w_prod10 >> RECIP10_SHIFT);
        r_q25 <= FS_W'(w_prod25 >> RECIP25_SHIFT);
    end

    assign w_edge   = i_full_scale - r_q25;
    assign w_raw    = r_bits[CHAN_BITS-1:0];
    assign w_v      = VALUE_W'(CHAN_OFFSET) - {1'b0, w_raw};
    assign w_v13    = {w_v[VALUE_W-1], w_v};
    assign w_half13 = {3'b000, i_full_scale[FS_W-1:1]};
    assign w_edge13 = {2'b00, w_edge};
    assign w_mag    = w_v[VALUE_W-1] ? (~w_v + 1'b1) : w_v;
    assign w_gt_neg_half = w_v13 > -w_half13;
    assign w_gt_half     = w_v13 > w_half13;

    assign w_last     = r_is_status || (r_chan == CH_W'(CHANNELS - 1));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_emit     = r_busy && w_out_free;
    assign o_pop      = !r_busy && i_job_valid;

    always_comb begin
        w_result = '0;
        if (r_is_status) begin
            w_result.report_kind = REPORT_STATUS;
            w_result.stale       = 1'b1;
            w_result.last        = 1'b1;
        end else begin
            w_result.report_kind     = REPORT_CHANNEL;
            w_result.channel_index   = CHAN_IDX_W'(r_chan);
            w_result.channel_value   = w_v;
            w_result.switch_position = {1'b0, w_gt_neg_half} + {1'b0, w_gt_half};
            w_result.stick_centered  = w_mag < {1'b0, r_q10};
            w_result.stick_high      = w_v13 > w_edge13;
            w_result.stick_low       = w_v13 < -w_edge13;
            w_result.flags_byte      = r_flags;
            w_result.stale           = 1'b0;
            w_result.last            = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_emit && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_status <= i_job.is_status;
            r_bits      <= i_job.bits;
            r_flags     <= i_job.flags;
            r_chan      <= '0;
        end else if (w_emit) begin
            r_bits <= {{CHAN_BITS{1'b0}}, r_bits[FRAME_DATA_BITS-1:CHAN_BITS]};
            r_chan <= r_chan + 1'b1;
        end
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/sbus_frame_decoder.sv =====
// The first report reaches the output register by way of the job queue and the channel unit's
// job registers, after the word completing a valid frame or the tick that sets stale.
// Throughput: one input word per cycle while the two-entry job queue has room; a frame
// then drains as CHANNELS reports, one per cycle from the single channel unit while ready is high.
// Reset (synchronous, active low) clears frame tracking, age, stale, the queue and the
// output; configuration returns to end marker 0, full scale 800, freshness 100 ms.
`default_nettype none
`include "sbus_frame_decoder_defines.svh"

module sbus_frame_decoder #(
    parameter int CHANNELS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    sbd_in_if.sink                              i_in_word,
    sbd_out_if.source                           o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sbd_pkg::*;

    logic [7:0]      r_end_marker;
    logic [FS_W-1:0] r_full_scale;
    logic [AGE_W-1:0] r_freshness;

    logic          w_push, w_pop;
    t_job          w_push_job, w_pop_job;
    t_queue_status w_qstat;

    logic          w_status_out;
    logic          w_chan_last_out;
    logic          w_top_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker <= END_MARKER_RESET;
            r_full_scale <= FULL_SCALE_RESET;
            r_freshness  <= FRESHNESS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_END_MARKER:   r_end_marker <= i_cfg_data[7:0];
                CFG_FULL_SCALE:   r_full_scale <= i_cfg_data[FS_W-1:0];
                CFG_FRESHNESS_MS: r_freshness  <= i_cfg_data[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sbd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in_word),
        .i_end_marker   (r_end_marker),
        .i_freshness_ms (r_freshness),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_job          (w_push_job)
    );

    sbd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_qstat)
    );

    sbd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_full_scale (r_full_scale),
        .i_job_valid  (!w_qstat.empty),
        .i_job        (w_pop_job),
        .o_pop        (w_pop),
        .o_out        (o_out_word)
    );

    assign w_status_out    = o_out_word.valid && (o_out_word.data.report_kind == REPORT_STATUS);
    assign w_chan_last_out = o_out_word.valid && o_out_word.data.last
                             && (o_out_word.data.report_kind == REPORT_CHANNEL);
    assign w_top_chan      = (o_out_word.data.channel_index == CHAN_IDX_W'(CHANNELS - 1));

    // The front only pushes when it has taken a word, and it takes none while full.
    `SBD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_push, !w_qstat.full)
    // A status report always closes its run and carries the stale flag.
    `SBD_ASSERT_NOW(a_status_form, i_clk, i_rst_n, w_status_out, o_out_word.data.last && o_out_word.data.stale)
    // A channel report that closes a frame is the highest channel.
    `SBD_ASSERT_NOW(a_last_chan, i_clk, i_rst_n, w_chan_last_out, w_top_chan)
    // Nothing leaves the block in the cycle after reset.
    `SBD_ASSERT_RESET(a_reset_idle, i_clk, i_rst_n, !o_out_word.valid && w_qstat.empty)

endmodule

`default_nettype wire
